// ===== hdl/pfa_pkg.sv =====
package pfa_pkg;

    localparam int NUM_PARTS_DEF = 16;
    localparam int SIZE_BITS_DEF = 16;
    localparam int PID_BITS_DEF  = 16;

    localparam int REQ_BITS  = 16;
    localparam int PROC_BITS = 16;
    localparam int SLOT_BITS = 4;

    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_BEST  = 2'd1;
    localparam logic [1:0] POL_WORST = 2'd2;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_ALLOC = 1'b1;

    typedef struct packed {
        logic                 action;
        logic [SLOT_BITS-1:0] slot_index;
        logic [REQ_BITS-1:0]  request_size;
        logic [PROC_BITS-1:0] process_id;
    } t_in_item;

    typedef struct packed {
        logic                 granted;
        logic [SLOT_BITS-1:0] chosen_index;
    } t_out_item;

    typedef struct packed {
        logic active;
        logic found;
    } t_scan_ctl;

    typedef struct packed {
        logic we;
        logic load;
    } t_commit_ctl;

endpackage

// ===== hdl/partition_fit_allocator_unit.sv =====
// Load item: the result is registered in the DONE state, then moves to the output register.
// Allocate item: the request walks the row of partition cells, one cell per cycle,
// then the result is registered in the DONE state and moves to the output register.
// One item is worked on at a time; the next is taken when the result enters the output
// register, and the input is stalled until then; DONE waits while the output is stalled.
// Synchronous active-low reset frees every partition, clears sizes and owners, selects first fit.
module partition_fit_allocator_unit #(
    parameter int NUM_PARTS = pfa_pkg::NUM_PARTS_DEF,
    parameter int SIZE_BITS = pfa_pkg::SIZE_BITS_DEF,
    parameter int PID_BITS  = pfa_pkg::PID_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  pfa_pkg::t_in_item i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output pfa_pkg::t_out_item o_out_item
);

    localparam int IDX_BITS = $clog2(NUM_PARTS);
    localparam int OW       = (IDX_BITS > pfa_pkg::SLOT_BITS) ? IDX_BITS : pfa_pkg::SLOT_BITS;
    localparam int CMP_BITS = (SIZE_BITS > pfa_pkg::REQ_BITS) ? SIZE_BITS : pfa_pkg::REQ_BITS;
    localparam int PW       = (PID_BITS > pfa_pkg::PROC_BITS) ? PID_BITS : pfa_pkg::PROC_BITS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } t_state;

    t_state                         r_state, n_state;
    logic [1:0]                     r_fit_policy;
    logic [PID_BITS-1:0]            r_pid;
    logic                           r_res_granted, n_res_granted;
    logic [pfa_pkg::SLOT_BITS-1:0]  r_res_idx, n_res_idx;
    logic                           r_out_valid, n_out_valid;
    pfa_pkg::t_out_item             r_out_item, n_out_item;

    pfa_pkg::t_scan_ctl             w_ctl  [NUM_PARTS+1];
    logic [pfa_pkg::REQ_BITS-1:0]   w_req  [NUM_PARTS+1];
    logic [IDX_BITS-1:0]            w_idx  [NUM_PARTS+1];
    logic [SIZE_BITS-1:0]           w_size [NUM_PARTS+1];

    pfa_pkg::t_commit_ctl           w_commit_ctl;
    logic [IDX_BITS-1:0]            w_commit_idx;
    logic [SIZE_BITS-1:0]           w_commit_size;

    logic                           w_accept;
    logic                           w_in_range;
    logic [OW-1:0]                  w_slot_ext;
    logic [OW-1:0]                  w_pick_ext;
    logic [CMP_BITS-1:0]            w_req_ext;
    logic [PW-1:0]                  w_pid_ext;
    pfa_pkg::t_scan_ctl             w_last;

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_in_range = 32'(i_in_item.slot_index) < NUM_PARTS;
    assign w_slot_ext = OW'(i_in_item.slot_index);
    assign w_req_ext  = CMP_BITS'(i_in_item.request_size);
    assign w_pid_ext  = PW'(i_in_item.process_id);
    assign w_last     = w_ctl[NUM_PARTS];
    assign w_pick_ext = OW'(w_idx[NUM_PARTS]);

    assign w_ctl[0].active = w_accept && (i_in_item.action == pfa_pkg::ACT_ALLOC);
    assign w_ctl[0].found  = 1'b0;
    assign w_req[0]        = i_in_item.request_size;
    assign w_idx[0]        = '0;
    assign w_size[0]       = '0;

    always_comb begin
        w_commit_ctl.load = (r_state == S_IDLE);
        w_commit_size     = w_req_ext[SIZE_BITS-1:0];
        if (r_state == S_IDLE) begin
            w_commit_ctl.we = w_accept && (i_in_item.action == pfa_pkg::ACT_LOAD) && w_in_range;
            w_commit_idx    = w_slot_ext[IDX_BITS-1:0];
        end else begin
            w_commit_ctl.we = (r_state == S_SCAN) && w_last.active && w_last.found;
            w_commit_idx    = w_idx[NUM_PARTS];
        end
    end

    for (genvar g = 0; g < NUM_PARTS; g++) begin : g_cell
        pfa_cell #(
            .CELL_IDX  (g),
            .SIZE_BITS (SIZE_BITS),
            .PID_BITS  (PID_BITS),
            .IDX_BITS  (IDX_BITS),
            .CMP_BITS  (CMP_BITS)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_policy      (r_fit_policy),
            .i_scan_ctl    (w_ctl[g]),
            .i_scan_req    (w_req[g]),
            .i_scan_idx    (w_idx[g]),
            .i_scan_size   (w_size[g]),
            .o_scan_ctl    (w_ctl[g+1]),
            .o_scan_req    (w_req[g+1]),
            .o_scan_idx    (w_idx[g+1]),
            .o_scan_size   (w_size[g+1]),
            .i_commit_ctl  (w_commit_ctl),
            .i_commit_idx  (w_commit_idx),
            .i_commit_size (w_commit_size),
            .i_commit_pid  (r_pid)
        );
    end

    always_comb begin
        n_state       = r_state;
        n_res_granted = r_res_granted;
        n_res_idx     = r_res_idx;
        n_out_valid   = r_out_valid;
        n_out_item    = r_out_item;
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_in_item.action == pfa_pkg::ACT_LOAD) begin
                        n_state       = S_DONE;
                        n_res_granted = w_in_range;
                        n_res_idx     = w_in_range ? i_in_item.slot_index : '0;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (w_last.active) begin
                    n_state       = S_DONE;
                    n_res_granted = w_last.found;
                    n_res_idx     = w_last.found ? w_pick_ext[pfa_pkg::SLOT_BITS-1:0] : '0;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_state                 = S_IDLE;
                    n_out_valid             = 1'b1;
                    n_out_item.granted      = r_res_granted;
                    n_out_item.chosen_index = r_res_idx;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_fit_policy <= pfa_pkg::POL_FIRST;
            r_out_valid  <= 1'b0;
            r_out_item   <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_out_item  <= n_out_item;
            if (i_cfg_we) begin
                r_fit_policy <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_granted <= n_res_granted;
        r_res_idx     <= n_res_idx;
        if (w_accept) begin
            r_pid <= w_pid_ext[PID_BITS-1:0];
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== hdl/pfa_cell.sv =====
module pfa_cell #(
    parameter int CELL_IDX  = 0,
    parameter int SIZE_BITS = pfa_pkg::SIZE_BITS_DEF,
    parameter int PID_BITS  = pfa_pkg::PID_BITS_DEF,
    parameter int IDX_BITS  = 4,
    parameter int CMP_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [1:0]                   i_policy,
    input  pfa_pkg::t_scan_ctl           i_scan_ctl,
    input  logic [pfa_pkg::REQ_BITS-1:0] i_scan_req,
    input  logic [IDX_BITS-1:0]          i_scan_idx,
    input  logic [SIZE_BITS-1:0]         i_scan_size,
    output pfa_pkg::t_scan_ctl           o_scan_ctl,
    output logic [pfa_pkg::REQ_BITS-1:0] o_scan_req,
    output logic [IDX_BITS-1:0]          o_scan_idx,
    output logic [SIZE_BITS-1:0]         o_scan_size,
    input  pfa_pkg::t_commit_ctl         i_commit_ctl,
    input  logic [IDX_BITS-1:0]          i_commit_idx,
    input  logic [SIZE_BITS-1:0]         i_commit_size,
    input  logic [PID_BITS-1:0]          i_commit_pid
);

    localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_IDX);

    logic [SIZE_BITS-1:0] r_size;
    logic                 r_busy;
    logic [PID_BITS-1:0]  r_owner;

    pfa_pkg::t_scan_ctl           r_scan_ctl;
    logic [pfa_pkg::REQ_BITS-1:0] r_scan_req;
    logic [IDX_BITS-1:0]          r_scan_idx;
    logic [SIZE_BITS-1:0]         r_scan_size;

    logic w_fits;
    logic w_take;
    logic w_hit;

    assign w_fits = !r_busy && (CMP_BITS'(r_size) >= CMP_BITS'(i_scan_req));
    assign w_hit  = i_commit_ctl.we && (i_commit_idx == MY_IDX);

    always_comb begin
        case (i_policy)
            pfa_pkg::POL_BEST: begin
                w_take = w_fits && (!i_scan_ctl.found || (r_size < i_scan_size));
            end
            pfa_pkg::POL_WORST: begin
                w_take = w_fits && (!i_scan_ctl.found || (r_size > i_scan_size));
            end
            default: begin
                w_take = w_fits && !i_scan_ctl.found;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size     <= '0;
            r_busy     <= 1'b0;
            r_owner    <= '0;
            r_scan_ctl <= '0;
        end else begin
            r_scan_ctl.active <= i_scan_ctl.active;
            r_scan_ctl.found  <= i_scan_ctl.found || w_take;
            if (w_hit) begin
                if (i_commit_ctl.load) begin
                    r_size  <= i_commit_size;
                    r_busy  <= 1'b0;
                    r_owner <= '0;
                end else begin
                    r_busy  <= 1'b1;
                    r_owner <= i_commit_pid;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_scan_req  <= i_scan_req;
        r_scan_idx  <= w_take ? MY_IDX : i_scan_idx;
        r_scan_size <= w_take ? r_size : i_scan_size;
    end

    assign o_scan_ctl  = r_scan_ctl;
    assign o_scan_req  = r_scan_req;
    assign o_scan_idx  = r_scan_idx;
    assign o_scan_size = r_scan_size;

endmodule
